### sv/dpn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpn_pkg: shared types for the dot product and norm unit
// Command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package dpn_pkg;

	// commands from controller to datapath
	typedef struct packed {
		logic s1_load;       // capture product of an accepted beat
		logic sq_sel;        // square elem_a instead of elem_a * elem_b
		logic acc_add;       // commit saturated sum of a non-last element
		logic out_load_sum;  // last element, dot mode: sum to output
		logic root_load;     // last element, norm mode: start root unit
		logic root_step;     // one root iteration
		logic out_load_root; // root to output
	} dpn_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic root_done;     // all root iterations finished
	} dpn_sts_t;

endpackage
`default_nettype wire

### sv/dpn_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpn_ifs: stream channels of the dot product and norm unit
// Element pair channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpn_in_if #(
	parameter int ELEM_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [ELEM_WIDTH-1:0] elem_a;
	logic signed [ELEM_WIDTH-1:0] elem_b;
	logic                         last;

	modport source (output valid, output action, output elem_a, output elem_b,
		output last, input ready);
	modport sink (input valid, input action, input elem_a, input elem_b,
		input last, output ready);
endinterface

interface dpn_out_if #(
	parameter int ACC_WIDTH = 48
);
	logic                        valid;
	logic                        ready;
	logic signed [ACC_WIDTH-1:0] result;
	logic                        saturated;

	modport source (output valid, output result, output saturated, input ready);
	modport sink (input valid, input result, input saturated, output ready);
endinterface
`default_nettype wire

### sv/dpn_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpn_isqrt: iterative floor integer square root
// Digit-by-digit restoring root, two radicand bits per cycle while step is high.
// ----------------------------------------------------------------------------
module dpn_isqrt #(
	parameter int ACC_WIDTH = 48
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       load,
	input  wire logic                       step,
	input  wire logic [ACC_WIDTH-1:0]       radicand,
	output logic [(ACC_WIDTH+1)/2-1:0]      root,
	output logic                            done
);
	localparam int RW = (ACC_WIDTH + 1) / 2;
	localparam int NW = 2 * RW;
	localparam int CW = $clog2(RW + 1);

	logic [NW-1:0]   n_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [CW-1:0]   cnt_q;

	logic [RW+1:0]   rem_sh;
	logic [RW+1:0]   trial;
	logic            ge;

	// one iteration: bring down two bits, try (4*root + 1)
	assign rem_sh = {rem_q[RW-1:0], n_q[NW-1:NW-2]};
	assign trial  = {root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(RW);
		end else if (step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			n_q    <= NW'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			n_q    <= {n_q[NW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[RW-2:0], ge};
		end
	end

	assign root = root_q;
	assign done = (cnt_q == '0);
endmodule
`default_nettype wire

### sv/dpn_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpn_datapath: multiply, saturating accumulate, root and output register
// Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module dpn_datapath #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 48
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dpn_pkg::dpn_cmd_t            cmd,
	output dpn_pkg::dpn_sts_t                 sts,
	input  wire logic signed [ELEM_WIDTH-1:0] elem_a,
	input  wire logic signed [ELEM_WIDTH-1:0] elem_b,
	output logic signed [ACC_WIDTH-1:0]       result,
	output logic                              saturated
);
	import dpn_pkg::*;

	localparam int PW   = 2 * ELEM_WIDTH;
	localparam int SUMW = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;
	localparam int HW   = SUMW - ACC_WIDTH + 1;
	localparam int RW   = (ACC_WIDTH + 1) / 2;

	logic signed [PW-1:0]         p_s1;
	logic signed [ACC_WIDTH-1:0]  acc_q;
	logic                         clip_q;
	logic                         rclip_q;
	logic signed [ACC_WIDTH-1:0]  result_q;
	logic                         sat_q;

	logic signed [ELEM_WIDTH-1:0] mul_b;
	logic signed [PW-1:0]         prod;
	logic signed [SUMW-1:0]       sum;
	logic [HW-1:0]                sum_hi;
	logic                         ovf;
	logic signed [ACC_WIDTH-1:0]  sat_val;
	logic                         clip_now;
	logic [ACC_WIDTH-1:0]         radicand;
	logic [RW-1:0]                root;

	// multiplier: square in norm mode
	assign mul_b = cmd.sq_sel ? elem_a : elem_b;
	assign prod  = elem_a * mul_b;

	always_ff @(posedge clk) begin
		if (cmd.s1_load) begin
			p_s1 <= prod;
		end
	end

	// saturating add; overflow when the sign bit and the bits above it disagree
	assign sum      = SUMW'(acc_q) + SUMW'(p_s1);
	assign sum_hi   = sum[SUMW-1:ACC_WIDTH-1];
	assign ovf      = !((&sum_hi) || !(|sum_hi));
	assign sat_val  = !ovf ? sum[ACC_WIDTH-1:0] :
		(sum[SUMW-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}});
	assign clip_now = clip_q | ovf;

	// accumulator, cleared when a vector closes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.out_load_sum || cmd.root_load) begin
			acc_q  <= '0;
			clip_q <= 1'b0;
		end else if (cmd.acc_add) begin
			acc_q  <= sat_val;
			clip_q <= clip_now;
		end
	end

	// root of the final sum, negative sums read as zero
	assign radicand = sat_val[ACC_WIDTH-1] ? '0 : sat_val;

	dpn_isqrt #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.root_load),
		.step     (cmd.root_step),
		.radicand (radicand),
		.root     (root),
		.done     (sts.root_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.root_load) begin
			rclip_q <= clip_now;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load_sum) begin
			result_q <= sat_val;
			sat_q    <= clip_now;
		end else if (cmd.out_load_root) begin
			result_q <= {{(ACC_WIDTH-RW){1'b0}}, root};
			sat_q    <= rclip_q;
		end
	end

	assign result    = result_q;
	assign saturated = sat_q;
endmodule
`default_nettype wire

### sv/dpn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpn_ctrl: controller of the dot product and norm unit
// Tracks vector mode, the product stage, root sequencing and output valid.
// ----------------------------------------------------------------------------
module dpn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_action,
	input  wire logic              in_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dpn_pkg::dpn_cmd_t      cmd,
	input  wire dpn_pkg::dpn_sts_t sts
);
	import dpn_pkg::*;

	typedef enum logic {
		S_RUN,
		S_ROOT
	} state_t;

	state_t state_q;
	logic   in_vector_q;
	logic   mode_q;
	logic   v_s1;
	logic   last_s1;
	logic   mode_s1;
	logic   out_valid_q;

	logic   in_fire;
	logic   mode_now;
	logic   out_free;
	logic   fin;

	// hold input while a last element or a root is in flight
	assign in_ready = (state_q == S_RUN) && !(v_s1 && last_s1);
	assign in_fire  = in_valid && in_ready;
	assign mode_now = in_vector_q ? mode_q : in_action;
	assign out_free = !out_valid_q || out_ready;
	assign fin      = v_s1 && last_s1 && (mode_s1 || out_free);

	// datapath commands
	always_comb begin
		cmd               = '0;
		cmd.s1_load       = in_fire;
		cmd.sq_sel        = mode_now;
		cmd.acc_add       = v_s1 && !last_s1;
		cmd.out_load_sum  = fin && !mode_s1;
		cmd.root_load     = fin && mode_s1;
		cmd.root_step     = (state_q == S_ROOT) && !sts.root_done;
		cmd.out_load_root = (state_q == S_ROOT) && sts.root_done && out_free;
	end

	// state and registered control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			in_vector_q <= 1'b0;
			mode_q      <= 1'b0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			mode_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				in_vector_q <= !in_last;
				mode_q      <= mode_now;
				last_s1     <= in_last;
				mode_s1     <= mode_now;
			end
			v_s1 <= in_fire || (v_s1 && last_s1 && !fin);

			unique case (state_q)
				S_RUN: begin
					if (cmd.root_load) begin
						state_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (cmd.out_load_root) begin
						state_q <= S_RUN;
					end
				end
				default: state_q <= S_RUN;
			endcase

			// output beat pending until taken
			if (cmd.out_load_sum || cmd.out_load_root) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

### sv/dot_product_and_norm_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dot_product_and_norm_unit: streaming dot product and Euclidean norm
// Top level joining the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
// One element pair is taken per cycle, unless the input is held as below,
// through a registered multiplier and a saturating accumulator. The beat
// marked last closes the vector: in dot mode the sum passes the product
// register into the output register and is then valid on the result channel,
// and the input is held while the closing beat sits in the product register.
// A dot sum that finds the output register still full holds the closing beat,
// and the input with it, until that register frees. In norm mode the
// iterative root unit, two radicand bits per cycle, runs between the closing
// beat and the result, and no element is taken while it runs. The mode is
// sampled on the first beat of each vector. A finished result waits in the
// output register while the next vector accumulates.
// ----------------------------------------------------------------------------
module dot_product_and_norm_unit #(
	parameter int ELEM_WIDTH = 16,
	parameter int ACC_WIDTH  = 48
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dpn_in_if.sink    elems,
	dpn_out_if.source results
);
	import dpn_pkg::*;

	dpn_cmd_t cmd;
	dpn_sts_t sts;

	dpn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elems.valid),
		.in_ready  (elems.ready),
		.in_action (elems.action),
		.in_last   (elems.last),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	dpn_datapath #(
		.ELEM_WIDTH (ELEM_WIDTH),
		.ACC_WIDTH  (ACC_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.elem_a    (elems.elem_a),
		.elem_b    (elems.elem_b),
		.result    (results.result),
		.saturated (results.saturated)
	);
endmodule
`default_nettype wire

### verif/dot_product_and_norm_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_product_and_norm_unit_tb: self-checking bench for the dot/norm unit
// Streams element pairs with bursty valid and a patterned result ready, and
// predicts every vector result (sum or floor root, plus clip flag) in a small
// scoreboard that checks the result channel in order.
// ----------------------------------------------------------------------------
package dpn_tb_pkg;

	localparam int ELEM_W = 16;
	localparam int ACC_W  = 48;

	// action codes on the element channel
	localparam logic ACT_DOT  = 1'b0;
	localparam logic ACT_NORM = 1'b1;

	localparam longint ACC_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	typedef struct {
		logic [ACC_W-1:0] value;
		logic             clipped;
	} vec_result_t;

	class dot_norm_scoreboard;
		longint      acc_sum;
		bit          norm_mode;
		bit          vec_open;
		bit          clip_seen;
		vec_result_t expected_q[$];
		int          fails;

		function new();
			acc_sum   = 0;
			norm_mode = 0;
			vec_open  = 0;
			clip_seen = 0;
			fails     = 0;
		endfunction

		// floor square root, built one result bit at a time from the top
		function longint unsigned root_floor(longint unsigned n);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int i = ACC_W / 2; i >= 0; i--) begin
				trial = root | (longint'(1) << i);
				if (trial * trial <= n)
					root = trial;
			end
			return root;
		endfunction

		// one accepted element beat
		function void note_elem(logic act, logic signed [ELEM_W-1:0] a,
			logic signed [ELEM_W-1:0] b, logic lst);
			longint      av;
			longint      bv;
			longint      sum;
			vec_result_t exp_res;
			av = a;
			bv = b;
			// mode is latched on the opening beat only
			if (!vec_open) begin
				norm_mode = (act == ACT_NORM);
				vec_open  = 1;
			end
			sum = acc_sum + (norm_mode ? av * av : av * bv);
			if (sum > ACC_MAX) begin
				acc_sum   = ACC_MAX;
				clip_seen = 1;
			end else if (sum < ACC_MIN) begin
				acc_sum   = ACC_MIN;
				clip_seen = 1;
			end else begin
				acc_sum = sum;
			end
			if (lst) begin
				if (norm_mode)
					exp_res.value = ACC_W'(root_floor(acc_sum > 0 ? acc_sum : 0));
				else
					exp_res.value = acc_sum[ACC_W-1:0];
				exp_res.clipped = clip_seen;
				expected_q.push_back(exp_res);
				acc_sum   = 0;
				clip_seen = 0;
				vec_open  = 0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			fails++;
		endtask

		// one accepted result beat against the oldest expectation
		task check_result(logic [ACC_W-1:0] value, logic sat);
			vec_result_t exp_res;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d sat %b with no vector closed",
					$signed(value), sat));
			end else begin
				exp_res = expected_q.pop_front();
				if (value !== exp_res.value)
					report($sformatf("result got %0d exp %0d", $signed(value),
						$signed(exp_res.value)));
				if (sat !== exp_res.clipped)
					report($sformatf("saturated got %b exp %b", sat, exp_res.clipped));
			end
		endtask

		function int unsigned waiting();
			return expected_q.size();
		endfunction
	endclass

endpackage

module dot_product_and_norm_unit_tb;
	import dpn_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 5000000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned RANDOM_ITEMS = 1330;
	// results accepted before the long receiver hold-off starts
	localparam int unsigned HOLD_AT = 80;
	localparam int unsigned HOLD_CYCLES = 400;
	// base beat count of the long vectors of full-scale products
	localparam int unsigned LONG_RUN = 64;

	localparam logic signed [ELEM_W-1:0] E_MIN = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam logic signed [ELEM_W-1:0] E_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam logic signed [ELEM_W-1:0] E_ONE = ELEM_W'(1 << 12);

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dpn_in_if #(.ELEM_WIDTH(ELEM_W)) elems();
	dpn_out_if #(.ACC_WIDTH(ACC_W)) results();

	dot_product_and_norm_unit #(
		.ELEM_WIDTH(ELEM_W),
		.ACC_WIDTH (ACC_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.elems  (elems),
		.results(results)
	);

	dot_norm_scoreboard vec_sb;
	int unsigned        cycle_count = 0;
	int unsigned        results_seen = 0;
	int                 burst_left = 0;
	bit                 fast_gaps = 0;

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** dot_product_and_norm_unit: FAILED **");
			$finish;
		end
	end

	// offer one beat, with a random gap first when a burst runs out
	task send_elem(logic act, logic signed [ELEM_W-1:0] a, logic signed [ELEM_W-1:0] b,
		logic lst);
		int gap;
		if (burst_left == 0) begin
			if (fast_gaps) begin
				gap        = ($urandom_range(0, 15) == 0) ? 1 : 0;
				burst_left = $urandom_range(200, 2000);
			end else begin
				gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
					: $urandom_range(1, 24);
			end
			if (gap != 0) begin
				elems.valid <= 1'b0;
				repeat (gap) begin
					elems.action <= 1'($urandom);
					elems.elem_a <= ELEM_W'($urandom);
					elems.elem_b <= ELEM_W'($urandom);
					elems.last   <= 1'($urandom);
					@(posedge clk);
				end
			end
		end
		burst_left--;
		elems.valid  <= 1'b1;
		elems.action <= act;
		elems.elem_a <= a;
		elems.elem_b <= b;
		elems.last   <= lst;
		@(posedge clk);
		while (!elems.ready)
			@(posedge clk);
		vec_sb.note_elem(act, a, b, lst);
	endtask

	function logic signed [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return E_MIN;
			1: return E_MAX;
			2: return ELEM_W'($signed($urandom_range(0, 2)) - 1);
			3: return ELEM_W'($signed($urandom_range(0, 511)) - 256);
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	task run_directed();
		// single-beat vectors at the corners of the element range
		send_elem(ACT_DOT, E_MIN, E_MIN, 1'b1);
		send_elem(ACT_DOT, E_MIN, E_MAX, 1'b1);
		send_elem(ACT_DOT, E_MAX, E_MAX, 1'b1);
		send_elem(ACT_NORM, E_MIN, 16'sd12345, 1'b1);
		send_elem(ACT_NORM, 16'sd0, E_MAX, 1'b1);
		send_elem(ACT_DOT, 16'sd0, 16'sd0, 1'b1);
		// action flips inside a dot vector: must stay dot
		send_elem(ACT_DOT, E_MAX, -16'sd1, 1'b0);
		send_elem(ACT_NORM, 16'sd1, 16'sd1, 1'b0);
		send_elem(ACT_NORM, -16'sd1, E_MAX, 1'b1);
		// action flips inside a norm vector: root of 3.0
		send_elem(ACT_NORM, E_ONE, E_MIN, 1'b0);
		send_elem(ACT_DOT, E_ONE, E_MAX, 1'b0);
		send_elem(ACT_DOT, E_ONE, 16'sd7, 1'b1);
		// alternating bit patterns, then a two-beat norm vector
		send_elem(ACT_DOT, 16'sh5555, 16'shAAAA, 1'b0);
		send_elem(ACT_DOT, 16'shAAAA, 16'sh5555, 1'b1);
		send_elem(ACT_NORM, E_MAX, E_MIN, 1'b0);
		send_elem(ACT_NORM, -16'sd1, 16'sd0, 1'b1);
	endtask

	task run_long_vectors();
		fast_gaps  = 1;
		burst_left = 0;
		// long dot vector of the largest positive product
		for (int unsigned i = 0; i < LONG_RUN; i++)
			send_elem(i == 0 ? ACT_DOT : 1'($urandom), E_MIN, E_MIN, i == LONG_RUN - 1);
		// drive the sum far negative, then climb back
		for (int unsigned i = 0; i < LONG_RUN + 12; i++) begin
			if (i < LONG_RUN + 8)
				send_elem(i == 0 ? ACT_DOT : 1'($urandom), E_MIN, E_MAX, 1'b0);
			else
				send_elem(1'($urandom), E_MAX, E_MAX, i == LONG_RUN + 11);
		end
		// norm of a long run of full-scale squares
		for (int unsigned i = 0; i < LONG_RUN; i++)
			send_elem(i == 0 ? ACT_NORM : 1'($urandom), E_MIN, ELEM_W'($urandom),
				i == LONG_RUN - 1);
		fast_gaps  = 0;
		burst_left = 0;
	endtask

	task run_random(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			for (int unsigned i = 0; i < len; i++)
				send_elem(1'($urandom), rand_elem(), rand_elem(), i == len - 1);
			sent += len;
		end
	endtask

	// stimulus and final verdict
	initial begin
		vec_sb = new();
		elems.valid  <= 1'b0;
		elems.action <= ACT_DOT;
		elems.elem_a <= '0;
		elems.elem_b <= '0;
		elems.last   <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_long_vectors();
		run_random(RANDOM_ITEMS);
		elems.valid <= 1'b0;
		while (vec_sb.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (vec_sb.fails == 0 && vec_sb.waiting() == 0) begin
			$display("** dot_product_and_norm_unit: PASSED **");
		end else begin
			$display("** dot_product_and_norm_unit: FAILED **");
		end
		$finish;
	end

	// result receiver: checks each beat, stalls on a changing pattern
	initial begin
		int unsigned hold_left;
		int unsigned stall_mode;
		int unsigned mode_left;
		hold_left  = 0;
		stall_mode = 0;
		mode_left  = 0;
		results.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (results.valid && results.ready) begin
				vec_sb.check_result(results.result, results.saturated);
				results_seen++;
				// long hold-off so the output register fills and input backs up
				if (results_seen == HOLD_AT)
					hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: results.ready <= 1'b1;
					1: results.ready <= ($urandom_range(0, 3) != 0);
					2: results.ready <= ($urandom_range(0, 3) == 0);
					default: results.ready <= ~results.ready;
				endcase
			end
		end
	end

endmodule

### files.f
sv/dpn_pkg.sv
sv/dpn_ifs.sv
sv/dpn_isqrt.sv
sv/dpn_datapath.sv
sv/dpn_ctrl.sv
sv/dot_product_and_norm_unit.sv
verif/dot_product_and_norm_unit_tb.sv
